// ===== sv/sphc_pkg.sv =====
package sphc_pkg;

   // Fixed field widths.
   localparam int RES_W      = 24;
   localparam int VOL_W      = 16;
   localparam int DEP_W      = 24;
   localparam int E_W        = 32;
   localparam int HIT_NUM_W  = 10;
   localparam int EVT_W      = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;

   // Divisor is the exact sum of the open hit energy and the step deposit.
   localparam int DEN_W = E_W + 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_RESOLUTION = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME     = 1'b1;

   localparam logic [RES_W-1:0] RES_RESET = 24'd256;
   localparam logic [VOL_W-1:0] VOL_RESET = 16'd1;

   // Input word kinds carried on tuser.
   localparam logic KIND_STEP = 1'b0;
   localparam logic KIND_EOE  = 1'b1;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

endpackage

// ===== sv/sphc_mul.sv =====
module sphc_mul #(
   parameter int A_W = 25,
   parameter int B_W = 32
) (
   input  logic                 clock,
   input  logic [A_W-1:0]       op_a,
   input  logic [B_W-1:0]       op_b,
   output logic [A_W+B_W-1:0]   prod
);

   logic [A_W+B_W-1:0] prod_ff;

   // One registered multiply; the product appears in the cycle after its operands.
   always_ff @(posedge clock) begin
      prod_ff <= (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);
   end

   assign prod = prod_ff;

endmodule

// ===== sv/sphc_div.sv =====
module sphc_div #(
   parameter int NUM_W = 56,
   parameter int QUO_W = 24,
   parameter int DEN_W = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // Restoring division, one quotient bit per cycle. The caller guarantees
   // that the quotient fits in QUO_W bits, so the upper numerator bits start
   // out below the divisor.
   always_comb begin
      trial    = {rem_ff, quo_ff[QUO_W-1]};
      diff     = trial - {1'b0, den_ff};
      ge       = trial >= {1'b0, den_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = DEN_W'(numer[NUM_W-1:QUO_W]);
         quo_in  = numer[QUO_W-1:0];
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/step_point_hit_clusterer_unit.sv =====
// Sequence: dropped or hit-opening steps and end-of-event markers finish in
// ST_IDLE; a marker that closes a hit passes ST_EMIT_LAST, a closing step
// ST_DIST, ST_DECIDE and ST_EMIT_NEW, a merged step ST_DIST, ST_DECIDE, then
// ST_MPROD and ST_MDIV per axis; the merge time is set by the shared bit-serial divider run once per axis.
// Throughput: one word at a time; the input is ready only between words.
// Reset: synchronous, active high; clears the open hit and the counters and
// loads resolution 256 and detector volume 1.
module step_point_hit_clusterer_unit #(
   parameter int POS_WIDTH          = 24,
   parameter int MAX_HITS_PER_EVENT = 1024
) (
   input  logic clock,
   input  logic reset,

   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  sphc_pkg::csr_index_type                 csr_index,
   input  logic [sphc_pkg::CSR_DATA_W-1:0]         csr_data,

   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // pos_x, pos_y, pos_z, deposit, volume_id (from bit 0 up), zero padded
   input  logic [((3*POS_WIDTH+40+7)/8)*8-1:0]     req_tdata,
   // kind
   input  logic                                    req_tuser,

   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // hit_x, hit_y, hit_z, hit_energy, hit_number, event_number (from bit 0 up)
   output logic [((3*POS_WIDTH+74+7)/8)*8-1:0]     rsp_tdata,
   output logic                                    rsp_tlast
);

   localparam int P     = POS_WIDTH;
   localparam int OUT_W = ((3*POS_WIDTH+74+7)/8)*8;
   localparam int HW    = $clog2(MAX_HITS_PER_EVENT);
   localparam int MA    = (P + 1 > sphc_pkg::RES_W) ? P + 1 : sphc_pkg::RES_W;
   localparam int MB    = (P + 1 > sphc_pkg::E_W) ? P + 1 : sphc_pkg::E_W;
   localparam int PW    = MA + MB;
   localparam int NMAG  = P + 32;
   localparam int NUMW  = P + 33;
   localparam int DW    = sphc_pkg::DEN_W;
   localparam int R2W   = 2 * sphc_pkg::RES_W;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_DIST      = 3'd1;
   localparam logic [2:0] ST_DECIDE    = 3'd2;
   localparam logic [2:0] ST_MPROD     = 3'd3;
   localparam logic [2:0] ST_MDIV      = 3'd4;
   localparam logic [2:0] ST_EMIT_NEW  = 3'd5;
   localparam logic [2:0] ST_EMIT_LAST = 3'd6;

   // Configuration.
   logic [sphc_pkg::RES_W-1:0] res_ff;
   logic [sphc_pkg::VOL_W-1:0] vol_ff;

   // Clustering state.
   logic [2:0]                 state_ff, state_in;
   logic [2:0]                 cnt_ff, cnt_in;
   logic [1:0]                 axis_ff, axis_in;
   logic                       open_ff, open_in;
   logic signed [P-1:0]        acc_ff [3];
   logic signed [P-1:0]        acc_in [3];
   logic [sphc_pkg::E_W-1:0]   acc_e_ff, acc_e_in;
   logic [HW-1:0]              hits_ff, hits_in;
   logic [sphc_pkg::EVT_W-1:0] evt_ff, evt_in;

   // Current step point and merge work registers.
   logic signed [P-1:0]        step_p_ff [3];
   logic signed [P-1:0]        step_p_in [3];
   logic [sphc_pkg::DEP_W-1:0] step_dep_ff, step_dep_in;
   logic [63:0]                d2_ff, d2_in;
   logic [R2W-1:0]             r2_ff, r2_in;
   logic signed [NUMW-1:0]     num_ff, num_in;
   logic [DW-1:0]              den_ff, den_in;
   logic                       neg_ff, neg_in;

   // Result register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]           rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;

   // Shared units.
   logic [MA-1:0]              mul_a;
   logic [MB-1:0]              mul_b;
   logic [PW-1:0]              prod;
   logic                       div_start;
   logic [NMAG-1:0]            div_num;
   logic                       div_done;
   logic [P-1:0]               div_quo;

   // Combinational helpers.
   logic                       req_acc;
   logic                       slot_free;
   logic [1:0]                 dsel;
   logic signed [P:0]          dist_diff;
   logic [P:0]                 dist_mag;
   logic signed [P-1:0]        acc_sel;
   logic signed [P-1:0]        step_sel;
   logic [P-1:0]               acc_mag;
   logic [P-1:0]               step_mag;
   logic [PW+63:0]             prod_ext;
   logic [64:0]                d2_sum;
   logic signed [NUMW-1:0]     prod_term;
   logic signed [NUMW-1:0]     num_base;
   logic signed [NUMW-1:0]     num_neg;
   logic                       term_neg;
   logic [HW+9:0]              hit_num_ext;
   logic [P-1:0]               in_p [3];
   logic [sphc_pkg::DEP_W-1:0] in_dep;
   logic [sphc_pkg::VOL_W-1:0] in_vol;
   logic [OUT_W-1:0]           hit_word;

   assign in_p[0] = req_tdata[P-1:0];
   assign in_p[1] = req_tdata[2*P-1:P];
   assign in_p[2] = req_tdata[3*P-1:2*P];
   assign in_dep  = req_tdata[3*P+23:3*P];
   assign in_vol  = req_tdata[3*P+39:3*P+24];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign hit_num_ext = {10'b0, hits_ff};
   assign hit_word = OUT_W'({evt_ff, hit_num_ext[9:0], acc_e_ff,
                             acc_ff[2], acc_ff[1], acc_ff[0]});

   sphc_mul #(
      .A_W (MA),
      .B_W (MB)
   ) u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   sphc_div #(
      .NUM_W (NMAG),
      .QUO_W (P),
      .DEN_W (DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_num),
      .denom    (den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Multiplier operand selection. In the distance phase the resolution is
   // squared first, then the three coordinate differences.
   always_comb begin
      dsel      = (cnt_ff == 3'd2) ? 2'd1 : ((cnt_ff == 3'd3) ? 2'd2 : 2'd0);
      dist_diff = {step_p_ff[dsel][P-1], step_p_ff[dsel]} -
                  {acc_ff[dsel][P-1], acc_ff[dsel]};
      dist_mag  = dist_diff[P] ? (P+1)'(-dist_diff) : (P+1)'(dist_diff);
      acc_sel   = acc_ff[axis_ff];
      step_sel  = step_p_ff[axis_ff];
      acc_mag   = acc_sel[P-1] ? P'(-acc_sel) : P'(acc_sel);
      step_mag  = step_sel[P-1] ? P'(-step_sel) : P'(step_sel);
      mul_a     = '0;
      mul_b     = '0;
      if (state_ff == ST_DIST) begin
         if (cnt_ff == 3'd0) begin
            mul_a = MA'(res_ff);
            mul_b = MB'(res_ff);
         end else begin
            mul_a = MA'(dist_mag);
            mul_b = MB'(dist_mag);
         end
      end else if (state_ff == ST_MPROD) begin
         if (cnt_ff == 3'd0) begin
            mul_a = MA'(acc_mag);
            mul_b = MB'(acc_e_ff);
         end else begin
            mul_a = MA'(step_mag);
            mul_b = MB'(step_dep_ff);
         end
      end
   end

   // Squares wrap at 64 bits and the distance sum saturates there.
   assign prod_ext = {64'b0, prod};
   assign d2_sum   = {1'b0, d2_ff} + {1'b0, prod_ext[63:0]};

   // Signed accumulation of the two weighted terms of one axis.
   assign prod_term = {1'b0, prod[NMAG-1:0]};
   assign term_neg  = (cnt_ff == 3'd1) ? acc_sel[P-1] : step_sel[P-1];
   assign num_base  = (cnt_ff == 3'd1) ? '0 : num_ff;
   assign num_neg   = -num_ff;
   assign div_num   = num_ff[NUMW-1] ? num_neg[NMAG-1:0] : num_ff[NMAG-1:0];
   assign div_start = (state_ff == ST_MDIV) && (cnt_ff == 3'd0);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      axis_in      = axis_ff;
      open_in      = open_ff;
      acc_in       = acc_ff;
      acc_e_in     = acc_e_ff;
      hits_in      = hits_ff;
      evt_in       = evt_ff;
      step_p_in    = step_p_ff;
      step_dep_in  = step_dep_ff;
      d2_in        = d2_ff;
      r2_in        = r2_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               step_p_in[0] = in_p[0];
               step_p_in[1] = in_p[1];
               step_p_in[2] = in_p[2];
               step_dep_in  = in_dep;
               if (req_tuser == sphc_pkg::KIND_EOE) begin
                  if (open_ff) begin
                     state_in = ST_EMIT_LAST;
                  end else begin
                     hits_in = '0;
                     evt_in  = evt_ff + 32'd1;
                  end
               end else if (in_dep != '0 && in_vol == vol_ff) begin
                  if (!open_ff) begin
                     open_in   = 1'b1;
                     acc_in[0] = in_p[0];
                     acc_in[1] = in_p[1];
                     acc_in[2] = in_p[2];
                     acc_e_in  = sphc_pkg::E_W'(in_dep);
                  end else begin
                     state_in = ST_DIST;
                     cnt_in   = 3'd0;
                     d2_in    = '0;
                  end
               end
            end
         end

         ST_DIST: begin
            // The product of the previous cycle's operands is consumed here.
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd1) begin
               r2_in = prod_ext[R2W-1:0];
            end else if (cnt_ff != 3'd0) begin
               d2_in = d2_sum[64] ? '1 : d2_sum[63:0];
            end
            if (cnt_ff == 3'd4) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            den_in = {1'b0, acc_e_ff} + DW'(step_dep_ff);
            if (d2_ff <= 64'(r2_ff)) begin
               state_in = ST_MPROD;
               axis_in  = 2'd0;
               cnt_in   = 3'd0;
            end else begin
               state_in = ST_EMIT_NEW;
            end
         end

         ST_MPROD: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff != 3'd0) begin
               num_in = term_neg ? num_base - prod_term : num_base + prod_term;
            end
            if (cnt_ff == 3'd2) begin
               state_in = ST_MDIV;
               cnt_in   = 3'd0;
            end
         end

         ST_MDIV: begin
            if (cnt_ff == 3'd0) begin
               neg_in = num_ff[NUMW-1];
               cnt_in = 3'd1;
            end else if (div_done) begin
               acc_in[axis_ff] = neg_ff ? -$signed(div_quo) : $signed(div_quo);
               cnt_in = 3'd0;
               if (axis_ff == 2'd2) begin
                  acc_e_in = den_ff[DW-1] ? '1 : den_ff[DW-2:0];
                  state_in = ST_IDLE;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = ST_MPROD;
               end
            end
         end

         ST_EMIT_NEW: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hit_word;
               rsp_last_in  = 1'b0;
               if (hits_ff < HW'(MAX_HITS_PER_EVENT - 1)) begin
                  hits_in = hits_ff + HW'(1);
               end
               acc_in   = step_p_ff;
               acc_e_in = sphc_pkg::E_W'(step_dep_ff);
               state_in = ST_IDLE;
            end
         end

         ST_EMIT_LAST: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hit_word;
               rsp_last_in  = 1'b1;
               open_in      = 1'b0;
               hits_in      = '0;
               evt_in       = evt_ff + 32'd1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff       <= sphc_pkg::RES_RESET;
         vol_ff       <= sphc_pkg::VOL_RESET;
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         axis_ff      <= '0;
         open_ff      <= 1'b0;
         acc_ff[0]    <= '0;
         acc_ff[1]    <= '0;
         acc_ff[2]    <= '0;
         acc_e_ff     <= '0;
         hits_ff      <= '0;
         evt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               sphc_pkg::CSR_RESOLUTION: res_ff <= csr_data;
               sphc_pkg::CSR_VOLUME:     vol_ff <= csr_data[sphc_pkg::VOL_W-1:0];
               default:                  res_ff <= res_ff;
            endcase
         end
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         axis_ff      <= axis_in;
         open_ff      <= open_in;
         acc_ff       <= acc_in;
         acc_e_ff     <= acc_e_in;
         hits_ff      <= hits_in;
         evt_ff       <= evt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_p_ff   <= step_p_in;
      step_dep_ff <= step_dep_in;
      d2_ff       <= d2_in;
      r2_ff       <= r2_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== verif/tb_step_point_hit_clusterer_unit.sv =====
`timescale 1ns / 100ps

module tb_step_point_hit_clusterer_unit;

   import sphc_pkg::*;

   localparam int POS_W        = 24;
   localparam int MAX_HITS     = 1024;
   localparam int REQ_W        = ((3*POS_W+40+7)/8)*8;
   localparam int RSP_W        = ((3*POS_W+74+7)/8)*8;
   localparam int DRAIN_CYCLES = 120;
   localparam int CYCLE_LIMIT  = 2000000;

   typedef struct {
      logic                    kind;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic [DEP_W-1:0]        deposit;
      logic [VOL_W-1:0]        volume;
   } step_word_t;

   typedef struct {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic [E_W-1:0]          energy;
      logic [HIT_NUM_W-1:0]    number;
      logic [EVT_W-1:0]        event_no;
      logic                    last;
   } hit_word_t;

   class hit_scoreboard;
      logic [RES_W-1:0]        resolution;
      logic [VOL_W-1:0]        volume;
      bit                      hit_open;
      logic signed [POS_W-1:0] acc_x, acc_y, acc_z;
      logic [E_W-1:0]          acc_energy;
      int unsigned             hits_in_event;
      logic [EVT_W-1:0]        events_seen;
      hit_word_t               pending[$];
      int                      errors;

      function new();
         resolution    = RES_RESET;
         volume        = VOL_RESET;
         hit_open      = 1'b0;
         acc_x         = '0;
         acc_y         = '0;
         acc_z         = '0;
         acc_energy    = '0;
         hits_in_event = 0;
         events_seen   = '0;
         errors        = 0;
      endfunction

      function void set_register(csr_index_type index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_RESOLUTION: resolution = value[RES_W-1:0];
            CSR_VOLUME:     volume     = value[VOL_W-1:0];
            default: ;
         endcase
      endfunction

      // Energy-weighted mean with the quotient truncated toward zero.
      function logic signed [POS_W-1:0] weighted_mean(longint a, longint unsigned wa,
                                                      longint b, longint unsigned wb);
         longint unsigned above, below, total, quot, mag_a, mag_b;
         above = 0;
         below = 0;
         total = wa + wb;
         mag_a = (a < 0) ? -a : a;
         mag_b = (b < 0) ? -b : b;
         if (a < 0) below += mag_a * wa;
         else above += mag_a * wa;
         if (b < 0) below += mag_b * wb;
         else above += mag_b * wb;
         if (total == 0) return a[POS_W-1:0];
         if (above >= below) quot = (above - below) / total;
         else quot = -((below - above) / total);
         return quot[POS_W-1:0];
      endfunction

      function hit_word_t current_hit(logic last);
         hit_word_t h;
         h.x        = acc_x;
         h.y        = acc_y;
         h.z        = acc_z;
         h.energy   = acc_energy;
         h.number   = hits_in_event[HIT_NUM_W-1:0];
         h.event_no = events_seen;
         h.last     = last;
         return h;
      endfunction

      function void note_input(step_word_t w);
         longint          dx, dy, dz;
         longint unsigned d2, r, r2, ea, sum;
         if (w.kind == KIND_EOE) begin
            if (hit_open) pending.push_back(current_hit(1'b1));
            hit_open      = 1'b0;
            hits_in_event = 0;
            events_seen   = events_seen + 1'b1;
            return;
         end
         if (w.deposit == 0 || w.volume != volume) return;
         if (hit_open) begin
            dx = longint'(w.x) - longint'(acc_x);
            dy = longint'(w.y) - longint'(acc_y);
            dz = longint'(w.z) - longint'(acc_z);
            d2 = dx*dx + dy*dy + dz*dz;
            r  = resolution;
            r2 = r * r;
            if (d2 <= r2) begin
               ea    = acc_energy;
               sum   = ea + w.deposit;
               acc_x = weighted_mean(acc_x, ea, w.x, w.deposit);
               acc_y = weighted_mean(acc_y, ea, w.y, w.deposit);
               acc_z = weighted_mean(acc_z, ea, w.z, w.deposit);
               acc_energy = (sum > 64'hFFFF_FFFF) ? {E_W{1'b1}} : sum[E_W-1:0];
               return;
            end
            pending.push_back(current_hit(1'b0));
            if (hits_in_event < MAX_HITS - 1) hits_in_event++;
         end
         hit_open   = 1'b1;
         acc_x      = w.x;
         acc_y      = w.y;
         acc_z      = w.z;
         acc_energy = w.deposit;
      endfunction

      function void compare_field(string field, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_result(hit_word_t got);
         hit_word_t want;
         if (pending.size() == 0) begin
            $error("hit word with nothing expected: x %0d y %0d z %0d energy %0d",
                   got.x, got.y, got.z, got.energy);
            errors++;
            return;
         end
         want = pending.pop_front();
         compare_field("hit_x", want.x, got.x);
         compare_field("hit_y", want.y, got.y);
         compare_field("hit_z", want.z, got.z);
         compare_field("hit_energy", want.energy, got.energy);
         compare_field("hit_number", want.number, got.number);
         compare_field("event_number", want.event_no, got.event_no);
         compare_field("last_of_event", want.last, got.last);
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index  = CSR_RESOLUTION;
   logic [CSR_DATA_W-1:0] csr_data   = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // pos_x, pos_y, pos_z, deposit, volume_id (from bit 0 up)
   logic [REQ_W-1:0]      req_tdata  = '0;
   // kind
   logic                  req_tuser  = KIND_STEP;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // hit_x, hit_y, hit_z, hit_energy, hit_number, event_number (from bit 0 up)
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;

   hit_scoreboard sb = new();
   int            send_idle_pct = 0;
   int            stall_pct     = 0;
   int            words_counted = 0;
   int            cycle_count;

   step_point_hit_clusterer_unit #(
      .POS_WIDTH          (POS_W),
      .MAX_HITS_PER_EVENT (MAX_HITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= reset ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      hit_word_t got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x        = rsp_tdata[0 +: POS_W];
         got.y        = rsp_tdata[POS_W +: POS_W];
         got.z        = rsp_tdata[2*POS_W +: POS_W];
         got.energy   = rsp_tdata[3*POS_W +: E_W];
         got.number   = rsp_tdata[3*POS_W+E_W +: HIT_NUM_W];
         got.event_no = rsp_tdata[3*POS_W+E_W+HIT_NUM_W +: EVT_W];
         got.last     = rsp_tlast;
         sb.check_result(got);
      end
   end

   function automatic logic signed [POS_W-1:0] random_coord();
      case ($urandom_range(0, 4))
         0:       return {1'b1, {(POS_W-1){1'b0}}} + POS_W'($urandom_range(0, 255));
         1:       return {1'b0, {(POS_W-1){1'b1}}} - POS_W'($urandom_range(0, 255));
         default: return POS_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [POS_W-1:0] near(logic signed [POS_W-1:0] c, int spread);
      longint v, lo, hi;
      lo = -(longint'(1) <<< (POS_W-1));
      hi = (longint'(1) <<< (POS_W-1)) - 1;
      v  = longint'(c) + longint'($urandom_range(0, 2*spread)) - spread;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v[POS_W-1:0];
   endfunction

   function automatic logic [DEP_W-1:0] random_deposit();
      case ($urandom_range(0, 9))
         0:       return {DEP_W{1'b1}};
         1:       return 1;
         2:       return DEP_W'($urandom_range(1, 255));
         default: return DEP_W'($urandom_range(1, (1 << DEP_W) - 1));
      endcase
   endfunction

   task automatic send_word(logic kind, logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                            logic signed [POS_W-1:0] z, logic [DEP_W-1:0] dep,
                            logic [VOL_W-1:0] vol);
      step_word_t w;
      w.kind    = kind;
      w.x       = x;
      w.y       = y;
      w.z       = z;
      w.deposit = dep;
      w.volume  = vol;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {vol, dep, z, y, x};
      do @(posedge clock); while (!req_tready);
      if (kind == KIND_EOE || (dep != 0 && vol == sb.volume)) words_counted++;
      sb.note_input(w);
   endtask

   task automatic write_register(csr_index_type index, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_register(index, value);
      @(posedge clock);
   endtask

   // Stop sending, let every pending hit drain, then give the block time to
   // finish a merge that produces no word.
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Steps scattered around one random center, with some dropped or
   // stray steps mixed in unless the cluster is meant to pile up energy.
   task automatic send_cluster(int steps, bit heavy);
      logic signed [POS_W-1:0] cx, cy, cz;
      int                      spread, pick;
      spread = (sb.resolution > 24'd4194304) ? 1048576 : int'(sb.resolution) / 4;
      cx = random_coord();
      cy = random_coord();
      cz = random_coord();
      repeat (steps) begin
         pick = heavy ? 99 : $urandom_range(0, 99);
         if (pick < 4)
            send_word(KIND_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
         else if (pick < 8)
            send_word(KIND_STEP, near(cx, spread), near(cy, spread), near(cz, spread),
                      '0, sb.volume);
         else if (pick < 12)
            send_word(KIND_STEP, cx, cy, cz, random_deposit(),
                      sb.volume ^ VOL_W'($urandom_range(1, 65535)));
         else
            send_word(KIND_STEP, near(cx, spread), near(cy, spread), near(cz, spread),
                      heavy ? {DEP_W{1'b1}} : random_deposit(), sb.volume);
      end
   endtask

   task automatic run_events(int n_items);
      bit paused;
      paused        = 1'b0;
      words_counted = 0;
      while (words_counted < n_items) begin
         repeat ($urandom_range(0, 4)) send_cluster($urandom_range(1, 6), 1'b0);
         send_word(KIND_EOE, $urandom, $urandom, $urandom, $urandom, $urandom);
         if (!paused && words_counted >= n_items / 2) begin
            settle_idle();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      int phase;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: an empty event, dropped steps, a merge exactly at the
      // resolution, a close, a step at the position extremes, end of event.
      send_word(KIND_EOE, -1, 7, 3, 24'hFFFFFF, 16'h0001);
      send_word(KIND_STEP, 10, 10, 10, 24'd0, 16'd1);
      send_word(KIND_STEP, 10, 10, 10, 24'd500, 16'd2);
      send_word(KIND_STEP, 0, 0, 0, 24'd100, 16'd1);
      send_word(KIND_STEP, 256, 0, 0, 24'd100, 16'd1);
      send_word(KIND_STEP, -100, -100, 0, 24'd1, 16'd1);
      send_word(KIND_STEP, 1000, 0, 0, 24'd7, 16'd1);
      send_word(KIND_STEP, -8388608, 8388607, 0, 24'hFFFFFF, 16'd1);
      send_word(KIND_EOE, 0, 0, 0, 24'd0, 16'd0);

      // Largest resolution: opposite corners along one axis still merge.
      settle_idle();
      write_register(CSR_RESOLUTION, 24'hFFFFFF);
      write_register(CSR_VOLUME, 24'h12FFFF);
      send_word(KIND_STEP, -8388608, -8388608, -8388608, 24'hFFFFFF, 16'hFFFF);
      send_word(KIND_STEP, 8388607, -8388608, -8388608, 24'hFFFFFF, 16'hFFFF);
      send_word(KIND_STEP, 8388607, 8388607, 8388607, 24'd1, 16'hFFFF);
      send_word(KIND_STEP, -5, -5, -5, 24'd3, 16'hFFFF);
      send_word(KIND_STEP, -6, -6, -6, 24'd1, 16'hFFFF);
      send_word(KIND_EOE, 8388607, -8388608, 1, 24'h800000, 16'h8000);

      // Zero resolution: only coincident steps merge.
      settle_idle();
      write_register(CSR_RESOLUTION, 24'd0);
      write_register(CSR_VOLUME, 24'hAB0000);
      send_word(KIND_STEP, 5, 5, 5, 24'd7, 16'd0);
      send_word(KIND_STEP, 5, 5, 5, 24'd3, 16'd0);
      send_word(KIND_STEP, 5, 5, 6, 24'd1, 16'd0);
      send_word(KIND_STEP, 5, 5, 6, 24'd9, 16'd1);
      send_word(KIND_EOE, 0, 0, 0, 24'd0, 16'd0);
      send_word(KIND_EOE, 0, 0, 0, 24'd0, 16'd0);

      // One long event with more hits than the hit counter can number.
      settle_idle();
      write_register(CSR_VOLUME, $urandom);
      words_counted = 0;
      while (words_counted < 1100) send_cluster(1, 1'b0);
      send_word(KIND_EOE, $urandom, $urandom, $urandom, $urandom, $urandom);

      for (phase = 0; phase < 4; phase++) begin
         settle_idle();
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
               write_register(CSR_RESOLUTION, $urandom_range(64, 8192));
               write_register(CSR_VOLUME, $urandom);
            end
            1: begin
               send_idle_pct = 52;
               stall_pct     = 0;
               write_register(CSR_RESOLUTION, 24'hFFFFFF);
               write_register(CSR_VOLUME, 24'h00FFFF);
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 52;
               write_register(CSR_RESOLUTION, $urandom);
               write_register(CSR_VOLUME, 24'h000000);
            end
            default: begin
               send_idle_pct = 21;
               stall_pct     = 21;
               write_register(CSR_RESOLUTION, 24'd4096);
               write_register(CSR_VOLUME, $urandom);
               // Enough full-scale deposits on one spot to saturate the energy.
               send_cluster(270, 1'b1);
               send_word(KIND_EOE, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
         endcase
         run_events(100);
      end

      settle_idle();
      if (sb.errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
